// File: rtl/core/sha1_stream_hash_macros.svh
// Assertion macros for the streaming SHA-1 hasher.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef SHA1_STREAM_HASH_MACROS_SVH
`define SHA1_STREAM_HASH_MACROS_SVH
`ifndef SYNTHESIS
`define SHA1S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHA1S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1S_ASSERT(label, prop, msg)
`define SHA1S_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/core/sha1s_pkg.sv
// Shared types and constants of the streaming SHA-1 hasher.
// No dependencies; every RTL module of the block uses it.
package sha1s_pkg;

  // One input transaction: a command and a message byte.
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  // One output transaction: a digest word and its last-word mark.
  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_item_t;

  // Operation codes after classification by the front end.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data;
  } op_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic compressing;
    logic padding;
    logic emitting;
  } status_t;

  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;

  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [7:0] PAD_BYTE       = 8'h80;

  // Round constants, index 0 for rounds 0 to 19.
  localparam logic [3:0][31:0] K_ROUND = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  // Initial chaining value, index 0 is H0.
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

endpackage

// File: rtl/core/sha1s_front.sv
// Front end of the SHA-1 hasher: input register and command classification.
// Depends on sha1s_pkg.
module sha1s_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sha1s_pkg::in_item_t item,
  output logic                push_valid,
  output sha1s_pkg::op_t      push_op,
  input  logic                queue_full
);

  logic           held_valid;
  sha1s_pkg::op_t held_op;
  sha1s_pkg::op_t classified;

  always_comb begin
    if (item.command) begin
      classified.opcode = sha1s_pkg::OP_FINISH;
      classified.data   = 8'h00;
    end else begin
      classified.opcode = sha1s_pkg::OP_ABSORB;
      classified.data   = item.data_byte;
    end
  end

  // The held transaction moves on whenever the queue has room.
  assign item_stall = held_valid && queue_full;
  assign push_valid = held_valid && !queue_full;
  assign push_op    = held_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (push_valid) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_op <= classified;
    end
  end

endmodule

// File: rtl/core/sha1s_queue.sv
// Small first-in first-out queue of classified operations.
// Depends on sha1s_pkg.
module sha1s_queue #(
  parameter int DEPTH_LOG2 = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  sha1s_pkg::op_t push_op,
  output logic           full,
  output logic           pop_valid,
  output sha1s_pkg::op_t pop_op,
  input  logic           pop_take
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  sha1s_pkg::op_t              entries [DEPTH];
  logic [DEPTH_LOG2-1:0]       wr_ptr;
  logic [DEPTH_LOG2-1:0]       rd_ptr;
  logic [DEPTH_LOG2:0]         count;
  logic                        do_push;
  logic                        do_pop;

  assign full      = (count == (DEPTH_LOG2 + 1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// File: rtl/core/sha1s_engine.sv
// Back end of the SHA-1 hasher: block window, padding, round unit and digest output.
// Depends on sha1s_pkg.
module sha1s_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  sha1s_pkg::op_t       op,
  output logic                 op_take,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output sha1s_pkg::out_item_t digest,
  output sha1s_pkg::status_t   status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [6:0] ROUND_LAST = 7'(sha1s_pkg::ROUNDS - 1);
  localparam logic [2:0] WORD_LAST  = 3'(sha1s_pkg::DIGEST_WORDS - 1);

  logic [2:0]  state;
  logic [31:0] h [sha1s_pkg::DIGEST_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [31:0] win [16];
  logic [6:0]  round;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [63:0] len_sr;
  logic        pad_first;
  logic        len_active;
  logic        pad_active;
  logic        final_blk;
  logic [2:0]  word_idx;

  logic        len_mode;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        start_block;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic        out_fire;

  function automatic logic [31:0] w_xor_rot(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  // Padding byte: 0x80 first, then zeros, then the bit length from byte 56 on.
  assign len_mode = !pad_first && ((fill == sha1s_pkg::FILL_LEN_START) || len_active);

  always_comb begin
    shift_en    = 1'b0;
    shift_byte  = 8'h00;
    start_block = 1'b0;
    op_take     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        op_take = op_valid;
        if (op_valid && (op.opcode == sha1s_pkg::OP_ABSORB)) begin
          shift_en    = 1'b1;
          shift_byte  = op.data;
          start_block = (fill == sha1s_pkg::FILL_LAST);
        end
      end
      ST_PAD: begin
        shift_en    = 1'b1;
        start_block = (fill == sha1s_pkg::FILL_LAST);
        if (pad_first) begin
          shift_byte = sha1s_pkg::PAD_BYTE;
        end else if (len_mode) begin
          shift_byte = len_sr[63:56];
        end else begin
          shift_byte = 8'h00;
        end
      end
      ST_ROUND, ST_FOLD, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (round < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = sha1s_pkg::K_ROUND[0];
    end else if (round < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = sha1s_pkg::K_ROUND[1];
    end else if (round < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = sha1s_pkg::K_ROUND[2];
    end else begin
      f_val = b ^ c ^ d;
      k_val = sha1s_pkg::K_ROUND[3];
    end
  end

  assign t_val = {a[26:0], a[31:27]} + f_val + e + k_val + win[0];
  assign w_new = {w_xor_rot(win[13] ^ win[8] ^ win[2] ^ win[0])};

  assign out_fire     = (state == ST_OUT) && !digest_stall;
  assign digest_valid = (state == ST_OUT);
  assign digest.digest_word = h[word_idx];
  assign digest.last_word   = (word_idx == WORD_LAST);

  assign status.compressing = (state == ST_ROUND) || (state == ST_FOLD);
  assign status.padding     = (state == ST_PAD);
  assign status.emitting    = (state == ST_OUT);

  // Control state and chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round      <= '0;
      fill       <= '0;
      byte_count <= '0;
      pad_first  <= 1'b0;
      len_active <= 1'b0;
      pad_active <= 1'b0;
      final_blk  <= 1'b0;
      word_idx   <= '0;
      for (int i = 0; i < sha1s_pkg::DIGEST_WORDS; i++) begin
        h[i] <= sha1s_pkg::H_INIT[i];
      end
    end else begin
      if (shift_en) begin
        fill <= fill + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (op_valid) begin
            if (op.opcode == sha1s_pkg::OP_ABSORB) begin
              byte_count <= byte_count + 1'b1;
              if (start_block) begin
                state <= ST_ROUND;
                round <= '0;
              end
            end else begin
              pad_first  <= 1'b1;
              len_active <= 1'b0;
              pad_active <= 1'b1;
              state      <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (len_mode) begin
            len_active <= 1'b1;
          end
          if (start_block) begin
            final_blk <= len_mode;
            if (len_mode) begin
              pad_active <= 1'b0;
            end
            state <= ST_ROUND;
            round <= '0;
          end
        end
        ST_ROUND: begin
          round <= round + 1'b1;
          if (round == ROUND_LAST) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          if (final_blk) begin
            state    <= ST_OUT;
            word_idx <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            if (word_idx == WORD_LAST) begin
              state      <= ST_IDLE;
              final_blk  <= 1'b0;
              byte_count <= '0;
              fill       <= '0;
              for (int i = 0; i < sha1s_pkg::DIGEST_WORDS; i++) begin
                h[i] <= sha1s_pkg::H_INIT[i];
              end
            end else begin
              word_idx <= word_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: message window, working variables and length shifter.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], shift_byte};
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end

    if (start_block) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == ST_ROUND) begin
      a <= t_val;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end

    if ((state == ST_IDLE) && op_valid && (op.opcode == sha1s_pkg::OP_FINISH)) begin
      len_sr <= {byte_count, 3'b000};
    end else if ((state == ST_PAD) && len_mode) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
  end

endmodule

// File: rtl/core/sha1_stream_hash.sv
// Streaming SHA-1 hasher. Each input transaction either absorbs one message
// byte (command 0) or finishes the message (command 1); a finish produces five
// output transactions carrying the digest words H0 to H4, the fifth marked by
// last_word, after which the hasher is back at its initial state for the next
// message. A front register and a small queue take input transactions while
// the back end is compressing or while the digest waits at the output. In the
// back end each full 64-byte block goes through the single round unit (80
// rounds, then a fold of the result into the chaining value), and no byte is
// absorbed meanwhile. A finish pads up to the end of the last block, byte by
// byte, compresses each padded block (one or two of them), and then offers the
// five digest words, one per cycle when the receiver does not stall. The queue
// depth is 2 to the power of QUEUE_DEPTH_LOG2 entries.
`include "sha1_stream_hash_macros.svh"

module sha1_stream_hash #(
  parameter int QUEUE_DEPTH_LOG2 = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  sha1s_pkg::in_item_t  item,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output sha1s_pkg::out_item_t digest
);

  // Classified operations travel from the front register into the queue.
  logic               push_valid;
  sha1s_pkg::op_t     push_op;
  logic               queue_full;

  // The engine pulls operations from the queue head when it is idle.
  logic               pop_valid;
  sha1s_pkg::op_t     pop_op;
  logic               pop_take;
  sha1s_pkg::status_t status;

  sha1s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push_valid (push_valid),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  sha1s_queue #(
    .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_take   (pop_take)
  );

  sha1s_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (pop_valid),
    .op           (pop_op),
    .op_take      (pop_take),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest),
    .status       (status)
  );

  // No digest word is offered in the cycle after a reset.
  `SHA1S_ASSERT_ALWAYS(a_no_digest_after_reset, rst |=> !digest_valid, "digest valid after reset")
  // Once the last digest word is taken, the engine returns to idle.
  `SHA1S_ASSERT(a_idle_after_last, (digest_valid && !digest_stall && digest.last_word) |=> !digest_valid, "digest valid after last word")
  // The round unit and the output never run at the same time.
  `SHA1S_ASSERT(a_no_digest_while_compressing, status.compressing |-> !digest_valid, "digest offered during compression")
  // The engine is in at most one of its working phases.
  `SHA1S_ASSERT(a_single_phase, $onehot0({status.compressing, status.padding, status.emitting}), "engine in more than one phase")

endmodule

// File: tb/sha1_stream_check.sv
`timescale 1ns / 100ps
// Checker for the streaming SHA-1 hasher: watches both channels, keeps its own SHA-1 state,
// and compares every digest word with the expected one. Depends on sha1s_pkg.
module sha1_stream_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  sha1s_pkg::in_item_t  item,
  input  logic                 digest_valid,
  input  logic                 digest_stall,
  input  sha1s_pkg::out_item_t digest,
  output int unsigned          err_count,
  output int unsigned          pending_cnt,
  output int unsigned          words_cnt
);

  localparam logic [31:0] K_0_19  = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  logic [31:0]          chain [5];
  logic [7:0]           blk [64];
  logic [60:0]          msg_len;
  sha1s_pkg::out_item_t expected_words [$];
  int unsigned          errs = 0;
  int unsigned          words = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    chain[4] = 32'hC3D2E1F0;
    msg_len  = '0;
  endtask

  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int unsigned s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0_19;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_20_39;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_40_59;
      end else begin
        f = b ^ c ^ d;
        k = K_60_79;
      end
      t = rotl(a, 5) + f + e + k + w[s];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endtask

  task automatic sha1_absorb(input logic [7:0] data);
    logic [5:0] fill;
    fill      = msg_len[5:0];
    blk[fill] = data;
    msg_len   = msg_len + 61'd1;
    if (fill == 6'd63) begin
      sha1_compress();
    end
  endtask

  // Pads the open block, appends the bit length (wrapping with the byte count), and queues
  // the five digest words before the chain starts over.
  task automatic close_message();
    logic [63:0]          bit_len;
    int                   pos;
    sha1s_pkg::out_item_t word;
    bit_len  = {msg_len, 3'b000};
    pos      = int'(msg_len[5:0]);
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (int j = 0; j < 8; j++) begin
      blk[56 + j] = bit_len[63 - 8*j -: 8];
    end
    sha1_compress();
    for (int j = 0; j < 5; j++) begin
      word.digest_word = chain[j];
      word.last_word   = (j == 4);
      expected_words.push_back(word);
    end
    restart_chain();
  endtask

  always @(posedge clk) begin
    sha1s_pkg::out_item_t exp_word;
    if (rst) begin
      restart_chain();
      expected_words.delete();
    end else begin
      // Compare first, so a digest word can never be matched against an expectation
      // created by an input transaction of the same edge.
      if (digest_valid && !digest_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest transaction, got word %h last %b",
                   $time, digest.digest_word, digest.last_word);
          errs++;
        end else begin
          exp_word = expected_words.pop_front();
          words++;
          if (digest.digest_word !== exp_word.digest_word) begin
            $display("%0t: digest_word expected %h, got %h",
                     $time, exp_word.digest_word, digest.digest_word);
            errs++;
          end
          if (digest.last_word !== exp_word.last_word) begin
            $display("%0t: last_word expected %b, got %b",
                     $time, exp_word.last_word, digest.last_word);
            errs++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.command == sha1s_pkg::OP_FINISH) begin
          close_message();
        end else begin
          sha1_absorb(item.data_byte);
        end
      end
    end
    err_count   <= errs;
    pending_cnt <= $unsigned(expected_words.size());
    words_cnt   <= words;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the streaming SHA-1 hasher testbench: clock, reset, message stimulus and verdict.
// Depends on sha1s_pkg, the sha1_stream_hash RTL and the sha1_stream_check module.
module tb_top;

  // Longest run of cycles with no transaction on either channel before the run is abandoned.
  // The slowest legitimate wait is a finish behind a full block: one compression, the padding
  // bytes, one more compression and a long receiver stall.
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 215;
  localparam int unsigned MIN_MESSAGES = 10;

  // Receiver behavior, changed at random.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  sha1s_pkg::in_item_t  item = '0;
  logic                 digest_valid;
  logic                 digest_stall = 1'b0;
  sha1s_pkg::out_item_t digest;

  int unsigned err_count;
  int unsigned pending_cnt;
  int unsigned words_cnt;

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned messages = 0;
  int unsigned longest_msg = 0;
  int unsigned idle_cycles = 0;

  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_phase_left = 0;
  logic [2:0]  rx_tick = '0;

  always #2 clk = ~clk;

  sha1_stream_hash u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  sha1_stream_check u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest),
    .err_count    (err_count),
    .pending_cnt  (pending_cnt),
    .words_cnt    (words_cnt)
  );

  // The receiver switches between no stalls, sparse stalls, dense stalls and a fixed periodic
  // pattern, so stalls land on different digest word positions over the run.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 3'd1;
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_FREE: begin
        digest_stall <= 1'b0;
      end
      RX_LIGHT: begin
        digest_stall <= ($urandom_range(0, 3) == 0);
      end
      RX_HEAVY: begin
        digest_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        digest_stall <= (rx_tick < 3'd5);
      end
    endcase
  end

  // Any cycle with a transaction on either side resets the watchdog.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one input transaction and returns at the edge where it is taken. The sender works
  // in bursts: when a burst runs out, valid drops for a random gap with junk on the payload,
  // and a new burst length is drawn. Now and then a burst is much longer, up to 120
  // transactions, with no gaps at all.
  task automatic send_txn(input logic cmd, input logic [7:0] data);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      item       <= {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    item_valid <= 1'b1;
    item       <= '{command: cmd, data_byte: data};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // A whole message of random bytes, closed by a finish whose data byte is random noise
  // that the hasher must ignore.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_txn(sha1s_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    send_txn(sha1s_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
    messages++;
    if (len > longest_msg) begin
      longest_msg = len;
    end
  endtask

  initial begin
    int unsigned sel;
    int unsigned len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty message right out of reset, then again with an all-ones byte on the finish,
    // which must not change the digest.
    send_txn(sha1s_pkg::OP_FINISH, 8'h00);
    send_txn(sha1s_pkg::OP_FINISH, 8'hFF);
    messages += 2;

    // The classic three-byte message.
    send_txn(sha1s_pkg::OP_ABSORB, 8'h61);
    send_txn(sha1s_pkg::OP_ABSORB, 8'h62);
    send_txn(sha1s_pkg::OP_ABSORB, 8'h63);
    send_txn(sha1s_pkg::OP_FINISH, 8'h00);

    // Byte extremes and alternating patterns, including a data byte equal to the pad byte,
    // then a finish straight after a finish.
    send_txn(sha1s_pkg::OP_ABSORB, 8'h00);
    send_txn(sha1s_pkg::OP_ABSORB, 8'hFF);
    send_txn(sha1s_pkg::OP_ABSORB, 8'hAA);
    send_txn(sha1s_pkg::OP_ABSORB, 8'h55);
    send_txn(sha1s_pkg::OP_ABSORB, 8'h80);
    send_txn(sha1s_pkg::OP_FINISH, 8'h7F);
    send_txn(sha1s_pkg::OP_FINISH, 8'h01);
    messages += 3;
    longest_msg = 5;

    // Random messages. Half are short, about a third sit at the padding boundaries where the
    // length either fits in the last block or forces a second one (55 to 57 and 63 to 65
    // bytes), and the rest are longer than one full block (66 to 130 bytes).
    while (items_sent < RANDOM_ITEMS + 13 || messages < MIN_MESSAGES) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        len = $urandom_range(0, 12);
      end else if (sel < 17) begin
        len = ($urandom_range(0, 1) ? 55 : 63) + $urandom_range(0, 2);
      end else begin
        len = $urandom_range(66, 130);
      end
      send_message(len);
    end
    item_valid <= 1'b0;

    // The last transaction was a finish, so everything left is its digest. The pending count
    // is registered in the checker, so it is sampled after each clock edge.
    do @(posedge clk); while (pending_cnt != 0);
    repeat (300) @(posedge clk);

    $display("Sent %0d input transactions in %0d messages, longest message %0d bytes.",
             items_sent, messages, longest_msg);
    $display("Compared %0d digest words under varying sender gaps and receiver stalls.",
             words_cnt);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
